>>> rtl/ordered_list_engine_unit_macros.svh
// Assertion macros shared by the ordered list engine RTL.
`ifndef ORDERED_LIST_ENGINE_UNIT_MACROS_SVH
`define ORDERED_LIST_ENGINE_UNIT_MACROS_SVH

// Same-cycle implication, checked on every clock edge out of reset.
`define OLE_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every clock edge out of reset.
`define OLE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/ole_pkg.sv
// Package with sizes, codes and controller/datapath interface types.
`timescale 1ns / 1ps
`default_nettype none

package ole_pkg;

    localparam int DEPTH  = 16;
    localparam int DATA_W = 32;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = ADDR_W + 1;
    localparam int OP_W   = 3;

    // Operation codes of a request.
    localparam logic [OP_W-1:0] OP_APPEND  = 3'd0;
    localparam logic [OP_W-1:0] OP_INSERT  = 3'd1;
    localparam logic [OP_W-1:0] OP_REMOVE  = 3'd2;
    localparam logic [OP_W-1:0] OP_SEARCH  = 3'd3;
    localparam logic [OP_W-1:0] OP_READ    = 3'd4;
    localparam logic [OP_W-1:0] OP_REVERSE = 3'd5;
    localparam logic [OP_W-1:0] OP_CLEAR   = 3'd6;

    // Memory write data source.
    localparam logic [1:0] WSRC_VAL   = 2'd0;
    localparam logic [1:0] WSRC_RDATA = 2'd1;
    localparam logic [1:0] WSRC_TMP   = 2'd2;

    // Pointer update.
    localparam logic [1:0] STEP_NONE = 2'd0;
    localparam logic [1:0] STEP_DOWN = 2'd1;
    localparam logic [1:0] STEP_UP   = 2'd2;
    localparam logic [1:0] STEP_IN   = 2'd3;

    // Entry count update.
    localparam logic [1:0] CNT_HOLD = 2'd0;
    localparam logic [1:0] CNT_INC  = 2'd1;
    localparam logic [1:0] CNT_DEC  = 2'd2;
    localparam logic [1:0] CNT_CLR  = 2'd3;

    typedef struct packed {
        logic       start;
        logic       rd_en;
        logic       rd_hi;
        logic       wr_en;
        logic       wr_hi;
        logic [1:0] wr_src;
        logic       tmp_ld;
        logic [1:0] step;
        logic [1:0] cnt;
        logic       set_err;
        logic       hit;
        logic       rd_cap;
        logic       out_ld;
    } t_dp_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            full;
        logic            pos_gt_cnt;
        logic            pos_ge_cnt;
        logic            hi_gt_pos;
        logic            hi_lt_cnt;
        logic            lo_lt_cnt;
        logic            lo_lt_hi;
        logic            match;
    } t_dp_sts;

endpackage

`default_nettype wire

>>> rtl/ole_datapath.sv
// Datapath: entry memory, pointers, entry count and result registers.
`timescale 1ns / 1ps
`default_nettype none

module ole_datapath (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  ole_pkg::t_dp_cmd            i_cmd,
    input  wire [ole_pkg::OP_W-1:0]     i_op,
    input  wire [ole_pkg::DATA_W-1:0]   i_value,
    input  wire [ole_pkg::CNT_W-1:0]    i_position,
    output ole_pkg::t_dp_sts            o_sts,
    output logic [ole_pkg::DATA_W-1:0]  o_read_value,
    output logic                        o_found,
    output logic [ole_pkg::ADDR_W-1:0]  o_found_index,
    output logic [ole_pkg::CNT_W-1:0]   o_count,
    output logic                        o_error
);

    logic [ole_pkg::DATA_W-1:0] r_mem [ole_pkg::DEPTH];
    logic [ole_pkg::DATA_W-1:0] r_rdata;
    logic [ole_pkg::DATA_W-1:0] r_tmp;

    logic [ole_pkg::OP_W-1:0]   r_op;
    logic [ole_pkg::DATA_W-1:0] r_value;
    logic [ole_pkg::CNT_W-1:0]  r_pos;
    logic [ole_pkg::CNT_W-1:0]  r_lo;
    logic [ole_pkg::CNT_W-1:0]  r_hi;
    logic [ole_pkg::CNT_W-1:0]  r_count;
    logic [ole_pkg::CNT_W-1:0]  n_count;

    logic [ole_pkg::DATA_W-1:0] r_rd_val;
    logic                       r_found;
    logic [ole_pkg::ADDR_W-1:0] r_fidx;
    logic                       r_err;

    logic [ole_pkg::ADDR_W-1:0] rd_addr;
    logic [ole_pkg::ADDR_W-1:0] wr_addr;
    logic [ole_pkg::DATA_W-1:0] wr_data;

    assign rd_addr = i_cmd.rd_hi ? r_hi[ole_pkg::ADDR_W-1:0] : r_lo[ole_pkg::ADDR_W-1:0];
    assign wr_addr = i_cmd.wr_hi ? r_hi[ole_pkg::ADDR_W-1:0] : r_lo[ole_pkg::ADDR_W-1:0];

    always_comb begin
        unique case (i_cmd.wr_src)
            ole_pkg::WSRC_VAL:   wr_data = r_value;
            ole_pkg::WSRC_RDATA: wr_data = r_rdata;
            default:             wr_data = r_tmp;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
        if (i_cmd.tmp_ld) begin
            r_tmp <= r_rdata;
        end
    end

    // Capture the request and set up the walk pointers for its operation.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_op    <= i_op;
            r_value <= i_value;
            r_pos   <= i_position;
            unique case (i_op)
                ole_pkg::OP_INSERT: begin
                    r_hi <= r_count;
                    r_lo <= r_count - ole_pkg::CNT_W'(1);
                end
                ole_pkg::OP_REMOVE: begin
                    r_lo <= i_position;
                    r_hi <= i_position + ole_pkg::CNT_W'(1);
                end
                ole_pkg::OP_REVERSE: begin
                    r_lo <= '0;
                    r_hi <= (r_count == '0) ? '0 : r_count - ole_pkg::CNT_W'(1);
                end
                ole_pkg::OP_READ: begin
                    r_lo <= i_position;
                    r_hi <= r_count;
                end
                default: begin
                    r_lo <= '0;
                    r_hi <= r_count;
                end
            endcase
        end else begin
            unique case (i_cmd.step)
                ole_pkg::STEP_DOWN: begin
                    r_lo <= r_lo - ole_pkg::CNT_W'(1);
                    r_hi <= r_hi - ole_pkg::CNT_W'(1);
                end
                ole_pkg::STEP_UP: begin
                    r_lo <= r_lo + ole_pkg::CNT_W'(1);
                    r_hi <= r_hi + ole_pkg::CNT_W'(1);
                end
                ole_pkg::STEP_IN: begin
                    r_lo <= r_lo + ole_pkg::CNT_W'(1);
                    r_hi <= r_hi - ole_pkg::CNT_W'(1);
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (i_cmd.cnt)
            ole_pkg::CNT_INC: n_count = r_count + ole_pkg::CNT_W'(1);
            ole_pkg::CNT_DEC: n_count = r_count - ole_pkg::CNT_W'(1);
            ole_pkg::CNT_CLR: n_count = '0;
            default:          n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // Per-transaction result, cleared when a request is taken.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_rd_val <= '0;
            r_found  <= 1'b0;
            r_fidx   <= '0;
            r_err    <= 1'b0;
        end else begin
            if (i_cmd.set_err) begin
                r_err <= 1'b1;
            end
            if (i_cmd.hit) begin
                r_found <= 1'b1;
                r_fidx  <= r_lo[ole_pkg::ADDR_W-1:0];
            end
            if (i_cmd.rd_cap) begin
                r_rd_val <= r_rdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_ld) begin
            o_read_value  <= r_rd_val;
            o_found       <= r_found;
            o_found_index <= r_fidx;
            o_count       <= r_count;
            o_error       <= r_err;
        end
    end

    assign o_sts.op         = r_op;
    assign o_sts.full       = (r_count == ole_pkg::CNT_W'(ole_pkg::DEPTH));
    assign o_sts.pos_gt_cnt = (r_pos > r_count);
    assign o_sts.pos_ge_cnt = (r_pos >= r_count);
    assign o_sts.hi_gt_pos  = (r_hi > r_pos);
    assign o_sts.hi_lt_cnt  = (r_hi < r_count);
    assign o_sts.lo_lt_cnt  = (r_lo < r_count);
    assign o_sts.lo_lt_hi   = (r_lo < r_hi);
    assign o_sts.match      = (r_rdata == r_value);

endmodule

`default_nettype wire

>>> rtl/ole_controller.sv
// Controller state machine that sequences each operation over the datapath.
`timescale 1ns / 1ps
`default_nettype none

module ole_controller (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_valid,
    output logic               o_stall,
    output logic               o_valid,
    input  wire                i_stall,
    input  ole_pkg::t_dp_sts   i_sts,
    output ole_pkg::t_dp_cmd   o_cmd
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DISP    = 4'd1;
    localparam logic [3:0] S_INS_RD  = 4'd2;
    localparam logic [3:0] S_INS_WR  = 4'd3;
    localparam logic [3:0] S_INS_FIN = 4'd4;
    localparam logic [3:0] S_REM_RD  = 4'd5;
    localparam logic [3:0] S_REM_WR  = 4'd6;
    localparam logic [3:0] S_SR_RD   = 4'd7;
    localparam logic [3:0] S_SR_CMP  = 4'd8;
    localparam logic [3:0] S_RD_RD   = 4'd9;
    localparam logic [3:0] S_RD_CAP  = 4'd10;
    localparam logic [3:0] S_RV_RLO  = 4'd11;
    localparam logic [3:0] S_RV_RHI  = 4'd12;
    localparam logic [3:0] S_RV_WLO  = 4'd13;
    localparam logic [3:0] S_RV_WHI  = 4'd14;
    localparam logic [3:0] S_FIN     = 4'd15;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_valid;
    logic       n_valid;

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_valid;

    always_comb begin
        n_state = r_state;
        n_valid = r_valid & i_stall;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_DISP;
                end
            end
            S_DISP: begin
                n_state = S_FIN;
                unique case (i_sts.op)
                    ole_pkg::OP_APPEND: begin
                        if (i_sts.full) begin
                            o_cmd.set_err = 1'b1;
                        end else begin
                            o_cmd.wr_en  = 1'b1;
                            o_cmd.wr_hi  = 1'b1;
                            o_cmd.wr_src = ole_pkg::WSRC_VAL;
                            o_cmd.cnt    = ole_pkg::CNT_INC;
                        end
                    end
                    ole_pkg::OP_INSERT: begin
                        if (i_sts.full || i_sts.pos_gt_cnt) begin
                            o_cmd.set_err = 1'b1;
                        end else begin
                            n_state = S_INS_RD;
                        end
                    end
                    ole_pkg::OP_REMOVE: begin
                        if (i_sts.pos_ge_cnt) begin
                            o_cmd.set_err = 1'b1;
                        end else begin
                            n_state = S_REM_RD;
                        end
                    end
                    ole_pkg::OP_SEARCH: begin
                        n_state = S_SR_RD;
                    end
                    ole_pkg::OP_READ: begin
                        if (i_sts.pos_ge_cnt) begin
                            o_cmd.set_err = 1'b1;
                        end else begin
                            n_state = S_RD_RD;
                        end
                    end
                    ole_pkg::OP_REVERSE: begin
                        n_state = S_RV_RLO;
                    end
                    ole_pkg::OP_CLEAR: begin
                        o_cmd.cnt = ole_pkg::CNT_CLR;
                    end
                    default: begin
                        o_cmd.set_err = 1'b1;
                    end
                endcase
            end
            // Insert shifts entries up by one, from the tail down to the position.
            S_INS_RD: begin
                if (i_sts.hi_gt_pos) begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = S_INS_WR;
                end else begin
                    n_state = S_INS_FIN;
                end
            end
            S_INS_WR: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_hi  = 1'b1;
                o_cmd.wr_src = ole_pkg::WSRC_RDATA;
                o_cmd.step   = ole_pkg::STEP_DOWN;
                n_state      = S_INS_RD;
            end
            S_INS_FIN: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_hi  = 1'b1;
                o_cmd.wr_src = ole_pkg::WSRC_VAL;
                o_cmd.cnt    = ole_pkg::CNT_INC;
                n_state      = S_FIN;
            end
            // Remove pulls every entry above the position down by one.
            S_REM_RD: begin
                if (i_sts.hi_lt_cnt) begin
                    o_cmd.rd_en = 1'b1;
                    o_cmd.rd_hi = 1'b1;
                    n_state     = S_REM_WR;
                end else begin
                    o_cmd.cnt = ole_pkg::CNT_DEC;
                    n_state   = S_FIN;
                end
            end
            S_REM_WR: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_src = ole_pkg::WSRC_RDATA;
                o_cmd.step   = ole_pkg::STEP_UP;
                n_state      = S_REM_RD;
            end
            S_SR_RD: begin
                if (i_sts.lo_lt_cnt) begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = S_SR_CMP;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_SR_CMP: begin
                if (i_sts.match) begin
                    o_cmd.hit = 1'b1;
                    n_state   = S_FIN;
                end else begin
                    o_cmd.step = ole_pkg::STEP_UP;
                    n_state    = S_SR_RD;
                end
            end
            S_RD_RD: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_RD_CAP;
            end
            S_RD_CAP: begin
                o_cmd.rd_cap = 1'b1;
                n_state      = S_FIN;
            end
            // Reverse swaps the outer pair and walks both ends inward.
            S_RV_RLO: begin
                if (i_sts.lo_lt_hi) begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = S_RV_RHI;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_RV_RHI: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_hi  = 1'b1;
                o_cmd.tmp_ld = 1'b1;
                n_state      = S_RV_WLO;
            end
            S_RV_WLO: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_src = ole_pkg::WSRC_RDATA;
                n_state      = S_RV_WHI;
            end
            S_RV_WHI: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_hi  = 1'b1;
                o_cmd.wr_src = ole_pkg::WSRC_TMP;
                o_cmd.step   = ole_pkg::STEP_IN;
                n_state      = S_RV_RLO;
            end
            S_FIN: begin
                // The result register takes the transaction once it is empty or draining.
                if (!r_valid || !i_stall) begin
                    o_cmd.out_ld = 1'b1;
                    n_valid      = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

endmodule

`default_nettype wire

>>> rtl/ordered_list_engine_unit.sv
// Top level of the ordered list engine: controller, datapath and interface checks.
// Append, clear and rejected requests finish in dispatch and go straight to the result register.
// Insert, remove and search add a read and a write or compare per entry shifted or compared, reverse
// a read, read, write and write per swapped pair; one memory access per cycle.
// Throughput: one request at a time, the next taken the cycle after its result is loaded.
// Synchronous active-low reset empties the list at once; entries need no clearing.
`timescale 1ns / 1ps
`default_nettype none
`include "ordered_list_engine_unit_macros.svh"

module ordered_list_engine_unit (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_valid,
    output logic                        o_stall,
    input  wire [ole_pkg::OP_W-1:0]     i_op,
    input  wire [ole_pkg::DATA_W-1:0]   i_value,
    input  wire [ole_pkg::CNT_W-1:0]    i_position,
    output logic                        o_valid,
    input  wire                         i_stall,
    output logic [ole_pkg::DATA_W-1:0]  o_read_value,
    output logic                        o_found,
    output logic [ole_pkg::ADDR_W-1:0]  o_found_index,
    output logic [ole_pkg::CNT_W-1:0]   o_count,
    output logic                        o_error
);

    ole_pkg::t_dp_cmd dp_cmd;
    ole_pkg::t_dp_sts dp_sts;

    logic in_accept;
    logic count_ok;
    logic rd_zero;
    logic no_data;

    ole_controller u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (dp_sts),
        .o_cmd   (dp_cmd)
    );

    ole_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .i_op          (i_op),
        .i_value       (i_value),
        .i_position    (i_position),
        .o_sts         (dp_sts),
        .o_read_value  (o_read_value),
        .o_found       (o_found),
        .o_found_index (o_found_index),
        .o_count       (o_count),
        .o_error       (o_error)
    );

    assign in_accept = i_valid && !o_stall;
    assign count_ok  = (o_count <= ole_pkg::CNT_W'(ole_pkg::DEPTH));
    assign rd_zero   = (o_read_value == '0);
    assign no_data   = rd_zero && !o_found;

    `OLE_ASSERT_NEXT(a_busy_after_accept, in_accept, o_stall, "second transaction taken")
    `OLE_ASSERT_SAME(a_count_bounded, o_valid, count_ok, "count above depth")
    `OLE_ASSERT_SAME(a_err_no_data, o_valid && o_error, no_data, "rejected request carries data")
    `OLE_ASSERT_SAME(a_found_no_read, o_valid && o_found, rd_zero, "search result has read data")

endmodule

`default_nettype wire

>>> tb/ole_list_checker.sv
// Checker that predicts and compares every result of the ordered list engine.
`timescale 1ns / 1ps

module ole_list_checker
    import ole_pkg::*;
(
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    input  wire               i_stall_in,
    input  wire [OP_W-1:0]    i_op,
    input  wire [DATA_W-1:0]  i_value,
    input  wire [CNT_W-1:0]   i_position,
    input  wire               i_out_valid,
    input  wire               i_out_stall,
    input  wire [DATA_W-1:0]  i_read_value,
    input  wire               i_found,
    input  wire [ADDR_W-1:0]  i_found_index,
    input  wire [CNT_W-1:0]   i_count,
    input  wire               i_error,
    output int                o_fail_count,
    output int                o_pending
);

    typedef struct packed {
        logic [DATA_W-1:0] read_value;
        logic              found;
        logic [ADDR_W-1:0] found_index;
        logic [CNT_W-1:0]  count;
        logic              error;
    } list_result_t;

    logic [DATA_W-1:0] list_mem [DEPTH];
    int                list_len;
    list_result_t      result_q [$];
    int                mismatch_total;

    // Applies one request to the shadow list and returns the result it yields.
    function automatic list_result_t apply_request(logic [OP_W-1:0] op,
                                                   logic [DATA_W-1:0] val,
                                                   logic [CNT_W-1:0] pos);
        list_result_t      res;
        int                n;
        int                p;
        int                idx;
        int                lo;
        int                hi;
        logic [DATA_W-1:0] tmp;
        res = '0;
        n   = list_len;
        p   = int'(pos);
        case (op)
            OP_APPEND: begin
                if (n >= DEPTH) begin
                    res.error = 1'b1;
                end else begin
                    list_mem[n] = val;
                    list_len    = n + 1;
                end
            end
            OP_INSERT: begin
                if (n >= DEPTH || p > n) begin
                    res.error = 1'b1;
                end else begin
                    for (idx = n; idx > p; idx--) list_mem[idx] = list_mem[idx-1];
                    list_mem[p] = val;
                    list_len    = n + 1;
                end
            end
            OP_REMOVE: begin
                if (p >= n) begin
                    res.error = 1'b1;
                end else begin
                    for (idx = p; idx + 1 < n; idx++) list_mem[idx] = list_mem[idx+1];
                    list_len = n - 1;
                end
            end
            OP_SEARCH: begin
                for (idx = 0; idx < n; idx++) begin
                    if (!res.found && list_mem[idx] == val) begin
                        res.found       = 1'b1;
                        res.found_index = idx[ADDR_W-1:0];
                    end
                end
            end
            OP_READ: begin
                if (p >= n) res.error = 1'b1;
                else        res.read_value = list_mem[p];
            end
            OP_REVERSE: begin
                lo = 0;
                hi = n - 1;
                while (lo < hi) begin
                    tmp          = list_mem[lo];
                    list_mem[lo] = list_mem[hi];
                    list_mem[hi] = tmp;
                    lo++;
                    hi--;
                end
            end
            OP_CLEAR: begin
                list_len = 0;
            end
            default: begin
                res.error = 1'b1;
            end
        endcase
        res.count = list_len[CNT_W-1:0];
        return res;
    endfunction

    initial begin
        list_len       = 0;
        mismatch_total = 0;
        o_fail_count   = 0;
        o_pending      = 0;
    end

    always @(posedge i_clk) begin
        list_result_t want;
        list_result_t got;
        if (!i_rst_n) begin
            list_len = 0;
            result_q.delete();
        end else begin
            if (i_valid && !i_stall_in)
                result_q.push_back(apply_request(i_op, i_value, i_position));
            if (i_out_valid && !i_out_stall) begin
                got = '{i_read_value, i_found, i_found_index, i_count, i_error};
                if (result_q.size() == 0) begin
                    mismatch_total++;
                    if (mismatch_total <= 10)
                        $display("%0t: result with no request waiting: value=%h found=%b idx=%0d count=%0d err=%b",
                                 $realtime, got.read_value, got.found, got.found_index,
                                 got.count, got.error);
                end else begin
                    want = result_q.pop_front();
                    if (got !== want) begin
                        mismatch_total++;
                        if (mismatch_total <= 10)
                            $display("%0t: expected value=%h found=%b idx=%0d count=%0d err=%b, got value=%h found=%b idx=%0d count=%0d err=%b",
                                     $realtime, want.read_value, want.found,
                                     want.found_index, want.count, want.error,
                                     got.read_value, got.found, got.found_index,
                                     got.count, got.error);
                    end
                end
            end
        end
        o_pending    <= result_q.size();
        o_fail_count <= mismatch_total;
    end

endmodule

>>> tb/tb_ordered_list_engine_unit.sv
// Top of the ordered list engine testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_ordered_list_engine_unit;
    import ole_pkg::*;

    localparam logic [OP_W-1:0] OP_UNDEF       = 3'd7;
    localparam int              WATCHDOG_LIMIT = 3000;
    localparam int              TAIL_CYCLES    = 60;
    localparam int              PHASE_ITEMS    = 50;
    localparam int              PHASE_COUNT    = 8;

    // Random request mixes.
    localparam int MIX_GROW   = 0;
    localparam int MIX_SHRINK = 1;
    localparam int MIX_ANY    = 2;

    logic              i_clk      = 1'b0;
    logic              i_rst_n    = 1'b0;
    logic              i_valid    = 1'b0;
    logic [OP_W-1:0]   i_op       = '0;
    logic [DATA_W-1:0] i_value    = '0;
    logic [CNT_W-1:0]  i_position = '0;
    logic              i_stall    = 1'b0;
    logic              o_stall;
    logic              o_valid;
    logic [DATA_W-1:0] o_read_value;
    logic              o_found;
    logic [ADDR_W-1:0] o_found_index;
    logic [CNT_W-1:0]  o_count;
    logic              o_error;

    int fail_count;
    int pending;
    int idle_cycles = 0;
    bit quiet       = 1'b0;

    ordered_list_engine_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_op          (i_op),
        .i_value       (i_value),
        .i_position    (i_position),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_read_value  (o_read_value),
        .o_found       (o_found),
        .o_found_index (o_found_index),
        .o_count       (o_count),
        .o_error       (o_error)
    );

    ole_list_checker i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_stall_in    (o_stall),
        .i_op          (i_op),
        .i_value       (i_value),
        .i_position    (i_position),
        .i_out_valid   (o_valid),
        .i_out_stall   (i_stall),
        .i_read_value  (o_read_value),
        .i_found       (o_found),
        .i_found_index (o_found_index),
        .i_count       (o_count),
        .i_error       (o_error),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_stall <= quiet ? 1'b0 : ($urandom_range(0, 99) < 9);
    end

    // Ends the run when neither channel moves a transaction for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Presents one request, with an occasional gap first, and holds it until taken.
    task automatic send_request(logic [OP_W-1:0] op, logic [DATA_W-1:0] val,
                                logic [CNT_W-1:0] pos);
        int gap;
        gap = 0;
        if (!quiet && $urandom_range(0, 99) < 9) gap = $urandom_range(1, 4);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_op       <= op;
        i_value    <= val;
        i_position <= pos;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Small value pool so that searches hit, mixed with fully random words.
    function automatic logic [DATA_W-1:0] pick_value();
        logic [DATA_W-1:0] pool [8];
        pool = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0002,
                 32'h8000_0000, 32'h7FFF_FFFF, 32'hA5A5_A5A5, 32'h0000_0003};
        if ($urandom_range(0, 99) < 60) return pool[$urandom_range(0, 7)];
        return $urandom;
    endfunction

    function automatic logic [CNT_W-1:0] pick_position(int mix);
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)                         return CNT_W'($urandom_range(17, 31));
        if (mix == MIX_SHRINK || r < 20)   return CNT_W'($urandom_range(0, 3));
        return CNT_W'($urandom_range(0, 16));
    endfunction

    function automatic logic [OP_W-1:0] OP_OP_PICK(int r);
        case (r % 6)
            0:       return OP_APPEND;
            1:       return OP_INSERT;
            2:       return OP_REMOVE;
            3:       return OP_SEARCH;
            4:       return OP_READ;
            default: return OP_REVERSE;
        endcase
    endfunction

    function automatic logic [OP_W-1:0] pick_op(int mix);
        int r;
        r = $urandom_range(0, 99);
        case (mix)
            MIX_GROW: begin
                if (r < 40) return OP_APPEND;
                if (r < 70) return OP_INSERT;
                if (r < 80) return OP_SEARCH;
                if (r < 90) return OP_READ;
                if (r < 95) return OP_REVERSE;
                return OP_REMOVE;
            end
            MIX_SHRINK: begin
                if (r < 45) return OP_REMOVE;
                if (r < 60) return OP_READ;
                if (r < 75) return OP_SEARCH;
                if (r < 85) return OP_APPEND;
                if (r < 95) return OP_REVERSE;
                return OP_INSERT;
            end
            default: begin
                if (r < 3)  return OP_UNDEF;
                if (r < 6)  return OP_CLEAR;
                return OP_OP_PICK(r);
            end
        endcase
    endfunction

    initial begin
        int mix;
        logic [OP_W-1:0] op;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Requests on an empty list, the undefined code and a bad insert position.
        send_request(OP_READ,    32'h0,          5'd0);
        send_request(OP_REMOVE,  32'h0,          5'd0);
        send_request(OP_SEARCH,  32'h0,          5'd0);
        send_request(OP_REVERSE, 32'h0,          5'd0);
        send_request(OP_CLEAR,   32'h0,          5'd0);
        send_request(OP_UNDEF,   32'hFFFF_FFFF,  5'd31);
        send_request(OP_INSERT,  32'h1234_5678,  5'd1);
        // Build a short list, inserting at the head, the tail and the middle.
        send_request(OP_INSERT,  32'hFFFF_FFFF,  5'd0);
        send_request(OP_APPEND,  32'h0000_0000,  5'd0);
        send_request(OP_APPEND,  32'h1234_5678,  5'd0);
        send_request(OP_INSERT,  32'h8000_0000,  5'd3);
        send_request(OP_INSERT,  32'h0000_0001,  5'd1);
        send_request(OP_SEARCH,  32'hFFFF_FFFF,  5'd0);
        send_request(OP_SEARCH,  32'h8000_0000,  5'd0);
        send_request(OP_SEARCH,  32'hDEAD_BEEF,  5'd0);
        send_request(OP_READ,    32'h0,          5'd4);
        send_request(OP_READ,    32'h0,          5'd5);
        send_request(OP_READ,    32'h0,          5'd31);
        send_request(OP_REVERSE, 32'h0,          5'd0);
        send_request(OP_READ,    32'h0,          5'd0);
        send_request(OP_REMOVE,  32'h0,          5'd4);
        send_request(OP_REMOVE,  32'h0,          5'd0);
        send_request(OP_REMOVE,  32'h0,          5'd7);
        send_request(OP_INSERT,  32'h5555_AAAA,  5'd31);
        send_request(OP_CLEAR,   32'h0,          5'd0);

        // Phases alternate growth, free mixing and shrinking; growth fills the list.
        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            case (phase % 4)
                0:       mix = MIX_GROW;
                2:       mix = MIX_SHRINK;
                default: mix = MIX_ANY;
            endcase
            quiet = (phase == 4);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                op = pick_op(mix);
                send_request(op, pick_value(), pick_position(mix));
            end
            if (phase == 2) wait_drained();
        end
        quiet = 1'b0;

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
